// ===== rtl/core/sqtc_pkg.sv =====
// Shared constants, payload types and helpers of the square transposition cipher.
package sqtc_pkg;

	// Smallest c with c*c >= v, worked out at elaboration only
	function automatic int ceil_sqrt(input int v);
		int c;
		c = 0;
		while (c * c < v) begin
			c = c + 1;
		end
		return c;
	endfunction

	localparam int MAX_CHARS = 1024;
	localparam int MAX_COLS  = ceil_sqrt(MAX_CHARS);
	localparam int ADDR_W    = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
	localparam int CNT_W     = $clog2(MAX_CHARS + 1);
	localparam int COL_W     = $clog2(MAX_COLS + 1);
	localparam int PTR_W     = $clog2(MAX_COLS * MAX_COLS + 2 * MAX_COLS + 1);
	localparam int CHAR_W    = 7;

	// Opcodes of the request channel
	localparam logic [1:0] OP_APPEND = 2'd0;
	localparam logic [1:0] OP_READ   = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	// Output selections of the mode register
	localparam logic [1:0] MODE_NORM   = 2'd0;
	localparam logic [1:0] MODE_ROWS   = 2'd1;
	localparam logic [1:0] MODE_CIPHER = 2'd2;
	localparam logic [1:0] MODE_CHUNK  = 2'd3;
	localparam logic [1:0] MODE_RESET  = MODE_CHUNK;

	localparam logic [7:0] SPACE_CHAR = 8'h20;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] in_byte;
	} req_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       out_valid;
		logic       is_last;
		logic [6:0] columns;
		logic [6:0] rows;
		logic       overflow;
	} rsp_t;

	// Handshake between the sequencer and the output stage
	typedef struct packed {
		logic idle;
		logic res_valid;
	} ctrl_stat_t;

endpackage

// ===== rtl/core/sqtc_ram.sv =====
// Generic single-port RAM with registered read.
module sqtc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic                             re,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] addr,
	input  logic [WIDTH-1:0]                 wdata,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port share one address
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

// ===== rtl/core/sqtc_ctrl.sv =====
// Sequencer: character store, square sizing and output walk of the cipher.
module sqtc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  sqtc_pkg::req_t      item,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_wdata,
	input  logic                res_take,
	output sqtc_pkg::ctrl_stat_t stat,
	output sqtc_pkg::rsp_t      res
);
	import sqtc_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_EXEC = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	state_t             state_q;
	logic [1:0]         op_q;
	logic [7:0]         byte_q;
	logic [1:0]         mode_q;
	logic [CNT_W-1:0]   kept_q;
	logic [COL_W-1:0]   cols_q;
	logic [COL_W-1:0]   rows_q;
	logic [COL_W-1:0]   fill_q;
	logic [PTR_W-1:0]   sq_q;
	logic [PTR_W-1:0]   area_q;
	logic [PTR_W-1:0]   emit_q;
	logic [PTR_W-1:0]   ptr_q;
	logic [COL_W-1:0]   wrow_q;
	logic [COL_W-1:0]   wcol_q;
	logic               ovf_q;
	logic               rvalid_q;
	logic               rlast_q;
	logic               rstore_q;

	logic               is_kept;
	logic [CHAR_W-1:0]  low_char;
	logic [PTR_W-1:0]   n_ext;
	logic [PTR_W-1:0]   cols_ext;
	logic [PTR_W-1:0]   rows_ext;
	logic [PTR_W-1:0]   total;
	logic               can_read;
	logic               rd_last;
	logic               rd_store;
	logic [PTR_W-1:0]   rd_addr;
	logic [PTR_W-1:0]   nxt_ptr;
	logic [COL_W-1:0]   nxt_wrow;
	logic [COL_W-1:0]   nxt_wcol;
	logic [COL_W-1:0]   wrow_inc;
	logic [COL_W-1:0]   wcol_inc;
	logic               room;
	logic               grow;
	logic [COL_W-1:0]   nxt_cols;
	logic [COL_W-1:0]   nxt_rows;
	logic [COL_W-1:0]   nxt_fill;
	logic [PTR_W-1:0]   nxt_sq;
	logic [PTR_W-1:0]   nxt_area;
	logic               ram_we;
	logic               ram_re;
	logic [ADDR_W-1:0]  ram_addr;
	logic [CHAR_W-1:0]  ram_rdata;

	// Keep letters and digits, fold upper case to lower case
	always_comb begin
		is_kept  = 1'b0;
		low_char = byte_q[CHAR_W-1:0];
		if (byte_q >= 8'h30 && byte_q <= 8'h39) begin
			is_kept = 1'b1;
		end else if (byte_q >= 8'h61 && byte_q <= 8'h7a) begin
			is_kept = 1'b1;
		end else if (byte_q >= 8'h41 && byte_q <= 8'h5a) begin
			is_kept  = 1'b1;
			low_char = byte_q[CHAR_W-1:0] | 7'h20;
		end
	end

	assign n_ext    = PTR_W'(kept_q);
	assign cols_ext = PTR_W'(cols_q);
	assign rows_ext = PTR_W'(rows_q);

	// Length of the selected output
	always_comb begin
		total = '0;
		if (kept_q != '0) begin
			unique case (mode_q)
				MODE_NORM:   total = n_ext;
				MODE_ROWS:   total = n_ext + rows_ext - PTR_W'(1);
				MODE_CIPHER: total = area_q;
				MODE_CHUNK:  total = area_q + cols_ext - PTR_W'(1);
			endcase
		end
	end

	assign can_read = emit_q < total;
	assign rd_last  = (emit_q + PTR_W'(1)) == total;
	assign wrow_inc = wrow_q + COL_W'(1);
	assign wcol_inc = wcol_q + COL_W'(1);

	// Next step of the output walk: store fetch or separator
	always_comb begin
		rd_store = 1'b0;
		rd_addr  = ptr_q;
		nxt_ptr  = ptr_q;
		nxt_wrow = wrow_q;
		nxt_wcol = wcol_q;
		unique case (mode_q)
			MODE_NORM: begin
				rd_store = 1'b1;
				rd_addr  = emit_q;
			end
			MODE_ROWS: begin
				if (wcol_q == cols_q) begin
					nxt_wcol = '0;
				end else begin
					rd_store = 1'b1;
					nxt_ptr  = ptr_q + PTR_W'(1);
					nxt_wcol = wcol_inc;
				end
			end
			MODE_CIPHER: begin
				rd_store = ptr_q < n_ext;
				if (wrow_inc == rows_q) begin
					nxt_wrow = '0;
					nxt_wcol = wcol_inc;
					nxt_ptr  = PTR_W'(wcol_inc);
				end else begin
					nxt_wrow = wrow_inc;
					nxt_ptr  = ptr_q + cols_ext;
				end
			end
			MODE_CHUNK: begin
				if (wrow_q >= rows_q) begin
					nxt_wrow = '0;
					nxt_wcol = wcol_inc;
					nxt_ptr  = PTR_W'(wcol_inc);
				end else begin
					rd_store = ptr_q < n_ext;
					nxt_wrow = wrow_inc;
					nxt_ptr  = ptr_q + cols_ext;
				end
			end
		endcase
	end

	// Step the square size by one kept character
	assign room = kept_q < CNT_W'(MAX_CHARS);
	assign grow = n_ext == sq_q;

	always_comb begin
		nxt_cols = cols_q;
		nxt_rows = rows_q;
		nxt_fill = fill_q;
		nxt_sq   = sq_q;
		nxt_area = area_q;
		if (grow) begin
			nxt_cols = cols_q + COL_W'(1);
			nxt_sq   = sq_q + {cols_ext[PTR_W-2:0], 1'b1};
			if (cols_q == '0) begin
				nxt_rows = COL_W'(1);
				nxt_fill = COL_W'(1);
				nxt_area = PTR_W'(1);
			end else begin
				nxt_rows = cols_q;
				nxt_fill = COL_W'(2);
				nxt_area = sq_q + cols_ext;
			end
		end else if (fill_q == cols_q) begin
			nxt_rows = rows_q + COL_W'(1);
			nxt_fill = COL_W'(1);
			nxt_area = area_q + cols_ext;
		end else begin
			nxt_fill = fill_q + COL_W'(1);
		end
	end

	// Store port: write on append, read on a fetching read
	always_comb begin
		ram_we   = 1'b0;
		ram_re   = 1'b0;
		ram_addr = rd_addr[ADDR_W-1:0];
		if (state_q == ST_EXEC) begin
			if (op_q == OP_APPEND) begin
				ram_we   = is_kept && room;
				ram_addr = kept_q[ADDR_W-1:0];
			end else if (op_q == OP_READ) begin
				ram_re = can_read && rd_store;
			end
		end
	end

	sqtc_ram #(
		.WIDTH (CHAR_W),
		.DEPTH (MAX_CHARS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (low_char),
		.rdata (ram_rdata)
	);

	// Sequence one item: capture, execute, hand over the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			mode_q   <= MODE_RESET;
			kept_q   <= '0;
			cols_q   <= '0;
			rows_q   <= '0;
			fill_q   <= '0;
			sq_q     <= '0;
			area_q   <= '0;
			emit_q   <= '0;
			ptr_q    <= '0;
			wrow_q   <= '0;
			wcol_q   <= '0;
			ovf_q    <= 1'b0;
			rvalid_q <= 1'b0;
			rlast_q  <= 1'b0;
			rstore_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_wdata;
				emit_q <= '0;
				ptr_q  <= '0;
				wrow_q <= '0;
				wcol_q <= '0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q  <= ST_FIN;
					rvalid_q <= 1'b0;
					rlast_q  <= 1'b0;
					rstore_q <= 1'b0;
					unique case (op_q)
						OP_APPEND: begin
							if (is_kept) begin
								if (room) begin
									kept_q <= kept_q + CNT_W'(1);
									cols_q <= nxt_cols;
									rows_q <= nxt_rows;
									fill_q <= nxt_fill;
									sq_q   <= nxt_sq;
									area_q <= nxt_area;
								end else begin
									ovf_q <= 1'b1;
								end
							end
							emit_q <= '0;
							ptr_q  <= '0;
							wrow_q <= '0;
							wcol_q <= '0;
						end
						OP_READ: begin
							if (can_read) begin
								rvalid_q <= 1'b1;
								rlast_q  <= rd_last;
								rstore_q <= rd_store;
								emit_q   <= emit_q + PTR_W'(1);
								ptr_q    <= nxt_ptr;
								wrow_q   <= nxt_wrow;
								wcol_q   <= nxt_wcol;
							end
						end
						OP_CLEAR: begin
							kept_q <= '0;
							cols_q <= '0;
							rows_q <= '0;
							fill_q <= '0;
							sq_q   <= '0;
							area_q <= '0;
							ovf_q  <= 1'b0;
							emit_q <= '0;
							ptr_q  <= '0;
							wrow_q <= '0;
							wcol_q <= '0;
						end
						default: begin
						end
					endcase
				end
				ST_FIN: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Capture the request payload on transfer
	always_ff @(posedge clk) begin
		if (start && state_q == ST_IDLE) begin
			op_q   <= item.opcode;
			byte_q <= item.in_byte;
		end
	end

	// Assemble the result from the store data and the updated sizes
	always_comb begin
		res           = '0;
		res.out_valid = rvalid_q;
		res.is_last   = rlast_q;
		res.columns   = 7'(cols_q);
		res.rows      = 7'(rows_q);
		res.overflow  = ovf_q;
		if (rvalid_q) begin
			res.out_char = rstore_q ? {1'b0, ram_rdata} : SPACE_CHAR;
		end
	end

	assign stat.idle      = state_q == ST_IDLE;
	assign stat.res_valid = state_q == ST_FIN;

endmodule

// ===== rtl/core/square_transposition_cipher.sv =====
// Top level of the square transposition cipher: channels and output register.
//
// Request channel (req_valid, req_stall, req): each transfer carries an opcode
// (append a raw byte, read the next output character, clear the message) and
// a byte. Response channel (rsp_valid, rsp_stall, rsp): exactly one result per
// request, in request order, with the character, its flags, the current
// square size and the overflow flag.
// Mode register: cfg_we with cfg_wdata selects the output form and restarts
// the read walk; write it only while the block is idle.
// Timing: a request is taken in the idle state, executed in the next cycle
// (one store write or one store read) and its result is loaded into the
// output register after the store's registered read, once that register
// is free. A new request can transfer only after the result is loaded and
// the block is idle again. req_stall is high while a request is at work.
// Stall: the output register holds its result while rsp_stall is high; a
// following request still runs and then waits with its result until the
// output register frees up.
// Reset: counts, sizes, walk and overflow flag clear, mode returns to chunked
// cipher; the store contents stay undefined and need no clearing pass.
module square_transposition_cipher (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  sqtc_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output sqtc_pkg::rsp_t  rsp,
	input  logic            cfg_we,
	input  logic [1:0]      cfg_wdata
);
	import sqtc_pkg::*;

	ctrl_stat_t stat;
	rsp_t       res;
	logic       start;
	logic       res_take;
	logic       rsp_valid_q;
	rsp_t       rsp_q;

	assign req_stall = !stat.idle;
	assign start     = req_valid && stat.idle;
	assign res_take  = stat.res_valid && (!rsp_valid_q || !rsp_stall);

	sqtc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item      (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.res_take  (res_take),
		.stat      (stat),
		.res       (res)
	);

	// Output register: load a finished result, drop it after transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_take) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== rtl/core/sqtc_checker.sv =====
// Port-level checks of the square transposition cipher, bound to the top level.
module sqtc_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            req_valid,
	input logic            req_stall,
	input logic            rsp_valid,
	input logic            rsp_stall,
	input sqtc_pkg::rsp_t  rsp
);
	import sqtc_pkg::*;

	// Hold a stalled result unchanged
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled result changed");

	// Refuse a new request right after a transfer
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while busy");

	// Keep the square no taller than wide, and both empty together
	a_shape: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.rows <= rsp.columns) &&
			((rsp.rows == 7'd0) == (rsp.columns == 7'd0)))
		else $error("inconsistent square size");

	// Drive zero character and no last flag on a result without character
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.out_valid |-> rsp.out_char == 8'd0 && !rsp.is_last)
		else $error("character on empty result");

endmodule

bind square_transposition_cipher sqtc_checker u_sqtc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

// ===== bench/cipher_reply_checker.sv =====
// Reply checker: watches both channels, predicts each reply and compares it field by field.
`timescale 1ns / 100ps
module cipher_reply_checker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	input  logic            req_stall,
	input  sqtc_pkg::req_t  req,
	input  logic            rsp_valid,
	input  logic            rsp_stall,
	input  sqtc_pkg::rsp_t  rsp,
	input  logic            cfg_we,
	input  logic [1:0]      cfg_wdata,
	output int              fail_count,
	output int              replies_due
);
	import sqtc_pkg::*;

	// Predicted block state
	logic [6:0] char_mem [0:MAX_CHARS-1];
	int         kept_len;
	int         sq_cols;
	int         sq_rows;
	int         emit_cnt;
	int         walk_r;
	int         walk_c;
	logic       ovf_seen;
	logic [1:0] cur_mode;

	// Replies predicted but not yet transferred, oldest first
	rsp_t pending_replies [$];

	function automatic int output_length();
		if (kept_len == 0) return 0;
		case (cur_mode)
			MODE_NORM:   return kept_len;
			MODE_ROWS:   return kept_len + sq_rows - 1;
			MODE_CIPHER: return sq_rows * sq_cols;
			default:     return sq_rows * sq_cols + sq_cols - 1;
		endcase
	endfunction

	// Pad past the message end with spaces
	function automatic logic [7:0] char_at(input int idx);
		if (idx < kept_len) return {1'b0, char_mem[idx]};
		return SPACE_CHAR;
	endfunction

	task automatic restart_walk();
		emit_cnt = 0;
		walk_r   = 0;
		walk_c   = 0;
	endtask

	// Produce the next character of the selected form and advance the walk
	task automatic advance_walk(output logic [7:0] ch);
		int seg_start;
		int seg_len;
		if (cur_mode == MODE_NORM) begin
			ch = char_at(emit_cnt);
		end else if (cur_mode == MODE_ROWS) begin
			seg_start = walk_r * sq_cols;
			seg_len   = (kept_len > seg_start) ? kept_len - seg_start : 0;
			if (seg_len > sq_cols) seg_len = sq_cols;
			if (walk_c >= seg_len) begin
				walk_r = walk_r + 1;
				walk_c = 0;
				ch     = SPACE_CHAR;
			end else begin
				ch     = char_at(seg_start + walk_c);
				walk_c = walk_c + 1;
			end
		end else if (cur_mode == MODE_CHUNK && walk_r >= sq_rows) begin
			walk_r = 0;
			walk_c = walk_c + 1;
			ch     = SPACE_CHAR;
		end else begin
			ch     = char_at(walk_r * sq_cols + walk_c);
			walk_r = walk_r + 1;
			if (cur_mode == MODE_CIPHER && walk_r >= sq_rows) begin
				walk_r = 0;
				walk_c = walk_c + 1;
			end
		end
	endtask

	// Apply one request to the predicted state and form its reply
	task automatic next_cipher_reply(input req_t r, output rsp_t e);
		int         total;
		logic       keep;
		logic [6:0] folded;
		e      = '0;
		keep   = 1'b1;
		folded = r.in_byte[6:0];
		case (r.opcode)
			OP_APPEND: begin
				if (r.in_byte >= "A" && r.in_byte <= "Z") folded = r.in_byte[6:0] + 7'd32;
				else if (!((r.in_byte >= "0" && r.in_byte <= "9") ||
					(r.in_byte >= "a" && r.in_byte <= "z"))) keep = 1'b0;
				if (keep) begin
					if (kept_len < MAX_CHARS) begin
						char_mem[kept_len] = folded;
						kept_len = kept_len + 1;
						while (sq_cols * sq_cols < kept_len) sq_cols = sq_cols + 1;
						sq_rows = (kept_len + sq_cols - 1) / sq_cols;
					end else begin
						ovf_seen = 1'b1;
					end
				end
				restart_walk();
			end
			OP_READ: begin
				total = output_length();
				if (emit_cnt < total) begin
					advance_walk(e.out_char);
					emit_cnt    = emit_cnt + 1;
					e.out_valid = 1'b1;
					e.is_last   = (emit_cnt == total);
				end
			end
			OP_CLEAR: begin
				kept_len = 0;
				sq_cols  = 0;
				sq_rows  = 0;
				ovf_seen = 1'b0;
				restart_walk();
			end
			default: begin
			end
		endcase
		e.columns  = sq_cols[6:0];
		e.rows     = sq_rows[6:0];
		e.overflow = ovf_seen;
	endtask

	task automatic compare_field(input string field, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			if (fail_count < 10)
				$display("%0t: reply %s mismatch: expected %0h, got %0h", $realtime, field, want, got);
			fail_count = fail_count + 1;
		end
	endtask

	// Track config writes and request transfers, check each reply transfer
	always @(posedge clk or negedge arst_n) begin : watch_channels
		rsp_t due;
		if (!arst_n) begin
			kept_len = 0;
			sq_cols  = 0;
			sq_rows  = 0;
			ovf_seen = 1'b0;
			cur_mode = MODE_RESET;
			restart_walk();
			pending_replies.delete();
		end else begin
			if (cfg_we) begin
				cur_mode = cfg_wdata;
				restart_walk();
			end
			if (req_valid && !req_stall) begin
				next_cipher_reply(req, due);
				pending_replies.push_back(due);
			end
			if (rsp_valid && !rsp_stall) begin
				if (pending_replies.size() == 0) begin
					if (fail_count < 10)
						$display("%0t: reply with none outstanding: %0h", $realtime, rsp);
					fail_count = fail_count + 1;
				end else begin
					due = pending_replies.pop_front();
					compare_field("out_char", due.out_char, rsp.out_char);
					compare_field("out_valid", {7'd0, due.out_valid}, {7'd0, rsp.out_valid});
					compare_field("is_last", {7'd0, due.is_last}, {7'd0, rsp.is_last});
					compare_field("columns", {1'b0, due.columns}, {1'b0, rsp.columns});
					compare_field("rows", {1'b0, due.rows}, {1'b0, rsp.rows});
					compare_field("overflow", {7'd0, due.overflow}, {7'd0, rsp.overflow});
				end
			end
		end
		replies_due = pending_replies.size();
	end

endmodule

// ===== bench/tb_top.sv =====
// Testbench top: clock, reset, request stimulus, reply stalls, watchdog and verdict.
`timescale 1ns / 100ps
module tb_top;
	import sqtc_pkg::*;

	localparam logic [1:0] OP_NOP       = 2'd3;
	localparam int         QUIET_LIMIT  = 2000;
	localparam int         DRAIN_CYCLES = 8;
	localparam int         PHASE_ITEMS  = 10;
	localparam int         PHASE_COUNT  = 8;
	localparam int         MSG_LIMIT    = 8;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       req_valid = 1'b0;
	logic       req_stall;
	req_t       req       = '0;
	logic       rsp_valid;
	logic       rsp_stall = 1'b0;
	rsp_t       rsp;
	logic       cfg_we    = 1'b0;
	logic [1:0] cfg_wdata = MODE_RESET;

	int fail_count;
	int replies_due;
	int send_idle_pct = 0;
	int stall_pct     = 0;
	int quiet_cycles  = 0;
	int items_sent    = 0;
	int msg_len       = 0;

	logic [1:0] mode_order [$] = '{MODE_NORM, MODE_ROWS, MODE_CIPHER, MODE_CHUNK};
	// Edges of the kept ranges: NUL, 0xFF, '/', '0', '9', ':', '@', 'A', 'Z', '[', '`', 'a', 'z', '{'
	logic [7:0] boundary_bytes [$] = '{8'h00, 8'hFF, 8'h2F, 8'h30, 8'h39, 8'h3A, 8'h40,
		8'h41, 8'h5A, 8'h5B, 8'h60, 8'h61, 8'h7A, 8'h7B};

	square_transposition_cipher u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	cipher_reply_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.rsp         (rsp),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.fail_count  (fail_count),
		.replies_due (replies_due)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Stall the reply channel at the current rate
	always @(posedge clk) begin
		rsp_stall <= ($urandom_range(99) < stall_pct);
	end

	// Abort when no transfer happens for too long
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic logic [7:0] random_alnum();
		int pick;
		pick = $urandom_range(61);
		if (pick < 10) return 8'(8'h30 + pick);
		if (pick < 36) return 8'(8'h41 + pick - 10);
		return 8'(8'h61 + pick - 36);
	endfunction

	// Mostly letters and digits, some arbitrary bytes that get filtered out
	function automatic logic [7:0] random_text_byte();
		if ($urandom_range(99) < 75) return random_alnum();
		return 8'($urandom_range(255));
	endfunction

	// Offer one request after a random gap and hold it until the transfer
	task automatic send_item(input logic [1:0] op, input logic [7:0] data);
		req_t item;
		item.opcode  = op;
		item.in_byte = data;
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		do @(posedge clk); while (req_stall);
		items_sent = items_sent + 1;
		if (op == OP_CLEAR) begin
			msg_len = 0;
		end else if (op == OP_APPEND && msg_len < MAX_CHARS &&
			((data >= 8'h30 && data <= 8'h39) || (data >= 8'h41 && data <= 8'h5A) ||
			(data >= 8'h61 && data <= 8'h7A))) begin
			msg_len = msg_len + 1;
		end
	endtask

	// Drain all replies, then write the mode register while idle
	task automatic set_mode(input logic [1:0] mode);
		req_valid <= 1'b0;
		do @(negedge clk); while (replies_due != 0);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= mode;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Read the whole output and a little past it, with some noise mixed in
	task automatic read_through(input int extra);
		int cols;
		int count;
		int roll;
		cols = 0;
		while (cols * cols < msg_len) cols = cols + 1;
		count = msg_len + 2 * cols + extra;
		repeat (count) begin
			roll = $urandom_range(99);
			if (roll < 2) send_item(OP_NOP, 8'($urandom_range(255)));
			else if (roll < 3) send_item(OP_APPEND, random_text_byte());
			else send_item(OP_READ, 8'($urandom_range(255)));
		end
	endtask

	initial begin
		int phase;
		int phase_end;
		int run_len;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty read, range edges, read past end, clear
		send_item(OP_READ, 8'hFF);
		foreach (boundary_bytes[i]) send_item(OP_APPEND, boundary_bytes[i]);
		read_through(-2);
		send_item(OP_CLEAR, 8'h00);
		send_item(OP_READ, 8'h00);

		// Random phases over every mode and idle profile
		for (phase = 0; phase < PHASE_COUNT; phase++) begin
			set_mode(mode_order[phase % 4]);
			case ((phase / 2) % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 78; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 78; end
				default: begin send_idle_pct = 16; stall_pct = 16; end
			endcase
			// Read the kept message from the top after the mode write
			repeat (3) send_item(OP_READ, 8'($urandom_range(255)));
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end) begin
				if (msg_len > MSG_LIMIT || $urandom_range(99) < 15)
					send_item(OP_CLEAR, 8'($urandom_range(255)));
				run_len = ($urandom_range(14) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 6);
				repeat (run_len) send_item(OP_APPEND, random_text_byte());
				if ($urandom_range(4) == 0) send_item(OP_NOP, 8'($urandom_range(255)));
				read_through($urandom_range(3));
			end
		end

		// Fill the store past capacity, then read and clear
		set_mode(MODE_NORM);
		send_idle_pct = 0;
		stall_pct     = 0;
		send_item(OP_CLEAR, 8'h00);
		repeat (MAX_CHARS + 6) send_item(OP_APPEND, random_alnum());
		send_item(OP_APPEND, 8'h2E);
		repeat (20) send_item(OP_READ, 8'($urandom_range(255)));
		set_mode(MODE_CHUNK);
		stall_pct = 16;
		repeat (40) send_item(OP_READ, 8'($urandom_range(255)));
		send_item(OP_CLEAR, 8'hFF);
		send_item(OP_READ, 8'h00);

		// Wait for the last replies, then give a stray one time to show up
		req_valid <= 1'b0;
		do @(negedge clk); while (replies_due != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
